// File: rtl/tvms_pkg.sv
// Shared types and constants for the tone vote mode selector.
`timescale 1ns / 1ps

package tvms_pkg;

	localparam int unsigned SPECTRUM_BINS = 1024;
	localparam int unsigned SEARCH_FIRST  = 130;
	localparam int unsigned SEARCH_LAST   = 185;

	localparam int unsigned CENTRE_REGS = 5;
	localparam int unsigned BIN_W       = 10;
	localparam int unsigned MAG_W       = 32;
	localparam int unsigned VOTE_W      = 8;
	localparam int unsigned BAND_W      = 3;
	localparam int unsigned HW_W        = 4;

	localparam logic [MAG_W-1:0]  MIN_LEVEL_RESET  = 32'd50000;
	localparam logic [VOTE_W-1:0] VOTE_LIMIT_RESET = 8'd5;
	localparam logic [HW_W-1:0]   HALF_WIDTH_RESET = 4'd1;
	localparam logic [CENTRE_REGS-1:0][BIN_W-1:0] CENTRE_RESET =
		{10'd183, 10'd170, 10'd157, 10'd144, 10'd131};

	typedef enum logic [2:0] {
		REG_MIN_LEVEL  = 3'd0,
		REG_VOTE_LIMIT = 3'd1,
		REG_HALF_WIDTH = 3'd2,
		REG_CENTRE0    = 3'd3,
		REG_CENTRE1    = 3'd4,
		REG_CENTRE2    = 3'd5,
		REG_CENTRE3    = 3'd6,
		REG_CENTRE4    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin_number;
		logic [MAG_W-1:0] magnitude;
		logic             frame_end;
		logic [2:0]       current_mode;
		logic             calibrating;
	} bin_item_t;

	typedef struct packed {
		logic              peak_valid;
		logic [BIN_W-1:0]  peak_bin;
		logic [BAND_W-1:0] winning_band;
		logic              votes_applied;
		logic              change_request;
	} result_t;

	// Peak of one finished frame, handed from the tracker to the band matcher.
	typedef struct packed {
		logic             peak_valid;
		logic [BIN_W-1:0] peak_bin;
		logic [2:0]       current_mode;
		logic             calibrating;
	} frame_rec_t;

	// Frame peak plus the band it votes for, handed to the voter.
	typedef struct packed {
		logic              vote_hit;
		logic [BAND_W-1:0] vote_band;
		logic              peak_valid;
		logic [BIN_W-1:0]  peak_bin;
		logic [2:0]        current_mode;
		logic              calibrating;
	} match_t;

endpackage

// File: rtl/tvms_tracker.sv
// Input register and per-frame peak search over the window.
`timescale 1ns / 1ps

module tvms_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            bin_valid,
	output logic                            bin_stall,
	input  tvms_pkg::bin_item_t             bin_data,
	input  logic [tvms_pkg::MAG_W-1:0]      min_level,
	output logic                            rec_valid,
	input  logic                            rec_ready,
	output tvms_pkg::frame_rec_t            rec
);

	logic                         v_s1;
	tvms_pkg::bin_item_t          item_s1;
	logic [tvms_pkg::MAG_W-1:0]   best_level_q;
	logic [tvms_pkg::BIN_W-1:0]   best_bin_q;
	logic                         best_found_q;

	logic                         in_win;
	logic [tvms_pkg::MAG_W-1:0]   thr;
	logic                         hit;
	logic                         found_nx;
	logic [tvms_pkg::BIN_W-1:0]   bin_nx;
	logic                         take_s1;
	logic                         load_s1;

	assign in_win = (32'(item_s1.bin_number) >= tvms_pkg::SEARCH_FIRST) &&
	                (32'(item_s1.bin_number) <= tvms_pkg::SEARCH_LAST) &&
	                (32'(item_s1.bin_number) < tvms_pkg::SPECTRUM_BINS);
	assign thr      = best_found_q ? best_level_q : min_level;
	assign hit      = in_win && (item_s1.magnitude > thr);
	assign found_nx = best_found_q | hit;
	assign bin_nx   = hit ? item_s1.bin_number : best_bin_q;

	// Only a frame end moves on; other bins retire here.
	assign take_s1   = v_s1 && (!item_s1.frame_end || rec_ready);
	assign load_s1   = !v_s1 || take_s1;
	assign bin_stall = !load_s1;

	assign rec_valid        = v_s1 && item_s1.frame_end;
	assign rec.peak_valid   = found_nx;
	assign rec.peak_bin     = found_nx ? bin_nx : '0;
	assign rec.current_mode = item_s1.current_mode;
	assign rec.calibrating  = item_s1.calibrating;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			best_level_q <= '0;
			best_bin_q   <= '0;
			best_found_q <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= bin_valid;
			end
			if (take_s1) begin
				if (item_s1.frame_end) begin
					// drop the search state for the next frame
					best_level_q <= '0;
					best_bin_q   <= '0;
					best_found_q <= 1'b0;
				end else if (hit) begin
					best_level_q <= item_s1.magnitude;
					best_bin_q   <= item_s1.bin_number;
					best_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && bin_valid) begin
			item_s1 <= bin_data;
		end
	end

endmodule

// File: rtl/tvms_match.sv
// Frame register and band matching of the frame peak against the centres.
`timescale 1ns / 1ps

module tvms_match #(
	parameter int BAND_COUNT = 5
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   rec_valid,
	output logic                                                   rec_ready,
	input  tvms_pkg::frame_rec_t                                   rec,
	input  logic [tvms_pkg::HW_W-1:0]                              band_half_width,
	input  logic [tvms_pkg::CENTRE_REGS-1:0][tvms_pkg::BIN_W-1:0]  centre,
	output logic                                                   match_valid,
	input  logic                                                   match_ready,
	output tvms_pkg::match_t                                       match
);

	logic                  v_s2;
	tvms_pkg::frame_rec_t  rec_s2;

	assign rec_ready   = !v_s2 || match_ready;
	assign match_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rec_ready) begin
			v_s2 <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			rec_s2 <= rec;
		end
	end

	// Walk from the top band down so the lowest matching band wins.
	always_comb begin
		logic [tvms_pkg::BIN_W-1:0] bin_gap;
		match.vote_hit     = 1'b0;
		match.vote_band    = '0;
		match.peak_valid   = rec_s2.peak_valid;
		match.peak_bin     = rec_s2.peak_bin;
		match.current_mode = rec_s2.current_mode;
		match.calibrating  = rec_s2.calibrating;
		for (int i = tvms_pkg::CENTRE_REGS - 1; i >= 0; i--) begin
			bin_gap = (rec_s2.peak_bin >= centre[i]) ? (rec_s2.peak_bin - centre[i])
			                                         : (centre[i] - rec_s2.peak_bin);
			if ((i < BAND_COUNT) && rec_s2.peak_valid &&
			    (bin_gap <= tvms_pkg::BIN_W'(band_half_width))) begin
				match.vote_hit  = 1'b1;
				match.vote_band = tvms_pkg::BAND_W'(i);
			end
		end
	end

endmodule

// File: rtl/tvms_voter.sv
// Vote counters, winner selection and the result register.
`timescale 1ns / 1ps

module tvms_voter #(
	parameter int BAND_COUNT = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          match_valid,
	output logic                          match_ready,
	input  tvms_pkg::match_t              match,
	input  logic [tvms_pkg::VOTE_W-1:0]   vote_limit,
	output logic                          res_valid,
	input  logic                          res_stall,
	output tvms_pkg::result_t             res_data
);

	logic [BAND_COUNT-1:0][tvms_pkg::VOTE_W-1:0] votes_q;
	logic [BAND_COUNT-1:0][tvms_pkg::VOTE_W-1:0] votes_inc;
	logic [tvms_pkg::VOTE_W-1:0]                 top;
	logic [tvms_pkg::BAND_W-1:0]                 win;
	logic                                        applied;
	logic                                        change;
	logic                                        take;
	logic                                        res_valid_q;
	tvms_pkg::result_t                           res_q;

	// Saturating increment of the matched band.
	always_comb begin
		for (int i = 0; i < BAND_COUNT; i++) begin
			if (match.vote_hit && (match.vote_band == tvms_pkg::BAND_W'(i)) &&
			    (votes_q[i] != '1)) begin
				votes_inc[i] = votes_q[i] + 1'b1;
			end else begin
				votes_inc[i] = votes_q[i];
			end
		end
	end

	// First band with the strictly largest count.
	always_comb begin
		top = votes_inc[0];
		win = '0;
		for (int i = 1; i < BAND_COUNT; i++) begin
			if (votes_inc[i] > top) begin
				top = votes_inc[i];
				win = tvms_pkg::BAND_W'(i);
			end
		end
	end

	assign applied = top > vote_limit;
	assign change  = applied && (win != match.current_mode) && !match.calibrating;

	assign match_ready = !res_valid_q || !res_stall;
	assign take        = match_valid && match_ready;
	assign res_valid   = res_valid_q;
	assign res_data    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			votes_q     <= '0;
		end else begin
			if (match_ready) begin
				res_valid_q <= match_valid;
			end
			if (take) begin
				votes_q <= applied ? '0 : votes_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.peak_valid     <= match.peak_valid;
			res_q.peak_bin       <= match.peak_bin;
			res_q.winning_band   <= win;
			res_q.votes_applied  <= applied;
			res_q.change_request <= change;
		end
	end

endmodule

// File: rtl/tone_vote_mode_selector_top.sv
// Top level of the tone vote mode selector: registers, peak tracker, matcher, voter.
// Throughput: one bin per cycle save a stalled frame end; others retire in the input stage.
// A frame result passes from its frame-end bin transfer through the input stage,
// the band match stage and the result register.
// The result register frees the input side; only a stalled, full path back-pressures.
// Reset clears all valids, the peak search, every vote counter and loads register defaults.
`timescale 1ns / 1ps

module tone_vote_mode_selector_top #(
	parameter int BAND_COUNT = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bin_valid,
	output logic                 bin_stall,
	input  tvms_pkg::bin_item_t  bin_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output tvms_pkg::result_t    res_data,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_idx,
	input  logic [31:0]          cfg_wdata
);

	logic [tvms_pkg::MAG_W-1:0]                           min_level_q;
	logic [tvms_pkg::VOTE_W-1:0]                          vote_limit_q;
	logic [tvms_pkg::HW_W-1:0]                            half_width_q;
	logic [tvms_pkg::CENTRE_REGS-1:0][tvms_pkg::BIN_W-1:0] centre_q;
	logic [2:0]                                           centre_sel;

	logic                  rec_valid;
	logic                  rec_ready;
	tvms_pkg::frame_rec_t  rec;
	logic                  match_valid;
	logic                  match_ready;
	tvms_pkg::match_t      match;

	assign centre_sel = cfg_idx - tvms_pkg::REG_CENTRE0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q  <= tvms_pkg::MIN_LEVEL_RESET;
			vote_limit_q <= tvms_pkg::VOTE_LIMIT_RESET;
			half_width_q <= tvms_pkg::HALF_WIDTH_RESET;
			centre_q     <= tvms_pkg::CENTRE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx) inside
				tvms_pkg::REG_MIN_LEVEL: begin
					min_level_q <= cfg_wdata;
				end
				tvms_pkg::REG_VOTE_LIMIT: begin
					vote_limit_q <= cfg_wdata[tvms_pkg::VOTE_W-1:0];
				end
				tvms_pkg::REG_HALF_WIDTH: begin
					half_width_q <= cfg_wdata[tvms_pkg::HW_W-1:0];
				end
				tvms_pkg::REG_CENTRE0, tvms_pkg::REG_CENTRE1, tvms_pkg::REG_CENTRE2,
				tvms_pkg::REG_CENTRE3, tvms_pkg::REG_CENTRE4: begin
					centre_q[centre_sel] <= cfg_wdata[tvms_pkg::BIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tvms_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin_data  (bin_data),
		.min_level (min_level_q),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

	tvms_match #(
		.BAND_COUNT (BAND_COUNT)
	) u_match (
		.clk             (clk),
		.arst_n          (arst_n),
		.rec_valid       (rec_valid),
		.rec_ready       (rec_ready),
		.rec             (rec),
		.band_half_width (half_width_q),
		.centre          (centre_q),
		.match_valid     (match_valid),
		.match_ready     (match_ready),
		.match           (match)
	);

	tvms_voter #(
		.BAND_COUNT (BAND_COUNT)
	) u_voter (
		.clk         (clk),
		.arst_n      (arst_n),
		.match_valid (match_valid),
		.match_ready (match_ready),
		.match       (match),
		.vote_limit  (vote_limit_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data)
	);

endmodule

// File: rtl/tvms_checker.sv
// Port-level assertions for the tone vote mode selector and their bind.
`timescale 1ns / 1ps

module tvms_checker #(
	parameter int BAND_COUNT = 5
) (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input tvms_pkg::result_t  res_data
);

	// Hold a stalled result transfer.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed or dropped");

	a_change_needs_apply: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.change_request |-> res_data.votes_applied)
		else $error("mode change without applied votes");

	a_no_peak_zero_bin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.peak_valid |-> res_data.peak_bin == '0)
		else $error("peak bin set without a peak");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res_data.winning_band) < BAND_COUNT)
		else $error("winning band out of range");

endmodule

bind tone_vote_mode_selector_top tvms_checker #(
	.BAND_COUNT (BAND_COUNT)
) u_tvms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
